// ===== rtl/ira_pkg.sv =====
`default_nettype none

package ira_pkg;

    // Width of the word that is converted, and the width of the value field.
    localparam int WORD_BITS = 32;
    localparam int VALUE_W   = 32;
    localparam int OPCODE_W  = 3;
    localparam int CHAR_W    = 7;

    // Decimal digits needed for the largest word: ceil(WORD_BITS * log10(2)).
    localparam int DEC_DIGITS = (WORD_BITS * 30103 + 99999) / 100000;
    localparam int BCD_W      = DEC_DIGITS * 4;

    // Shift register for the power-of-two radixes, with room for top padding.
    localparam int SH_W = WORD_BITS + 3;

    // Digit counts and top padding for the power-of-two radixes.
    localparam int ND_BIN = WORD_BITS;
    localparam int ND_OCT = (WORD_BITS + 2) / 3;
    localparam int ND_HEX = (WORD_BITS + 3) / 4;
    localparam int PAD_OCT = ND_OCT * 3 - WORD_BITS;
    localparam int PAD_HEX = ND_HEX * 4 - WORD_BITS;

    // Counter wide enough for the longest digit run and the conversion pass.
    localparam int CNT_W = $clog2(WORD_BITS + 1);

    // Format codes.
    localparam logic [OPCODE_W-1:0] OP_SDEC = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_UDEC = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_BIN  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_OCT  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_HEXL = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_HEXU = 3'd5;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] ASC_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASC_LOWA  = 7'h61;
    localparam logic [CHAR_W-1:0] ASC_UPA   = 7'h41;
    localparam logic [CHAR_W-1:0] ASC_MINUS = 7'h2D;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OPCODE_W-1:0] opcode;
    } t_req;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last_char;
    } t_res;

    // Maps a digit value 0 to 15 onto its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = ASC_ZERO + {3'b000, d};
        end else if (upper) begin
            c = ASC_UPA + {3'b000, d - 4'd10};
        end else begin
            c = ASC_LOWA + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_radix_ascii.sv =====
`default_nettype none

// Channel   Ports                     Handshake
// -------   -----------------------   ---------------------------------------------
// request   i_start, i_req, o_busy    taken at a rising edge with i_start & !o_busy
// result    o_strobe, o_res           valid for one cycle while o_strobe is high
//
// While a request is in hand o_busy stays high: decimal runs a double-dabble pass
// over all WORD_BITS bits, then scans DEC_DIGITS digits; binary, octal and hex scan
// ND_BIN, ND_OCT or ND_HEX digits. The scan visits one digit per cycle and strobes
// at most one character; leading zeros pass without a strobe, and a minus sign goes
// out in the cycle after acceptance. Reset is synchronous and active low and returns
// the sequencer to idle. The receiver cannot stall: every strobed character is taken.
module integer_to_radix_ascii (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ira_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_strobe,
    output ira_pkg::t_res      o_res
);
    import ira_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // Control state.
    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic                r_seen,  n_seen;
    logic                r_strobe, n_strobe;

    // Payload state.
    logic [OPCODE_W-1:0] r_op,  n_op;
    logic [SH_W-1:0]     r_sh,  n_sh;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    t_res                r_res, n_res;

    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_mag;
    logic [SH_W-1:0]      w_top;
    logic [BCD_W-1:0]     w_bcd_adj;
    logic [3:0]           w_digit;
    logic                 w_accept;
    logic                 w_is_dec;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_is_dec = (r_op == OP_SDEC) || (r_op == OP_UDEC);

    // Take the low WORD_BITS bits of the value, zero-extended when wider.
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            w_word[i] = (i < VALUE_W) ? i_req.value[i % VALUE_W] : 1'b0;
        end
    end

    // Signed decimal prints the magnitude; the most negative word wraps to 2^(W-1),
    // which reads correctly as an unsigned magnitude.
    assign w_mag = (i_req.opcode == OP_SDEC && w_word[WORD_BITS-1]) ?
                   (~w_word + WORD_BITS'(1)) : w_word;

    // Word aligned to the top of the shift register.
    assign w_top = {w_mag, 3'b000};

    // Double-dabble correction: each BCD digit of five or more gets three added.
    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            d = r_bcd[4*k +: 4];
            w_bcd_adj[4*k +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    // Current most significant digit for the stored format.
    always_comb begin
        case (r_op) inside
            OP_BIN:  w_digit = {3'b000, r_sh[SH_W-1]};
            OP_OCT:  w_digit = {1'b0, r_sh[SH_W-1 -: 3]};
            OP_HEXL, OP_HEXU: w_digit = r_sh[SH_W-1 -: 4];
            default: w_digit = r_bcd[BCD_W-1 -: 4];
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_seen   = r_seen;
        n_strobe = 1'b0;
        n_op     = r_op;
        n_sh     = r_sh;
        n_bcd    = r_bcd;
        n_res    = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op   = i_req.opcode;
                    n_seen = 1'b0;
                    n_bcd  = '0;
                    case (i_req.opcode) inside
                        OP_SDEC, OP_UDEC: begin
                            n_sh    = w_top;
                            n_cnt   = CNT_W'(WORD_BITS);
                            n_state = S_CONV;
                            // The sign goes out right away, ahead of the digits.
                            if (i_req.opcode == OP_SDEC && w_word[WORD_BITS-1]) begin
                                n_strobe       = 1'b1;
                                n_res.char_out  = ASC_MINUS;
                                n_res.last_char = 1'b0;
                            end
                        end
                        OP_BIN: begin
                            n_sh    = w_top;
                            n_cnt   = CNT_W'(ND_BIN);
                            n_state = S_EMIT;
                        end
                        OP_OCT: begin
                            n_sh    = w_top >> PAD_OCT;
                            n_cnt   = CNT_W'(ND_OCT);
                            n_state = S_EMIT;
                        end
                        OP_HEXL, OP_HEXU: begin
                            n_sh    = w_top >> PAD_HEX;
                            n_cnt   = CNT_W'(ND_HEX);
                            n_state = S_EMIT;
                        end
                        default: begin
                            // Undefined format codes produce no characters.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                // One binary bit enters the BCD register per cycle.
                n_bcd = {w_bcd_adj[BCD_W-2:0], r_sh[SH_W-1]};
                n_sh  = r_sh << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = CNT_W'(DEC_DIGITS);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Walk the digits from the top; leading zeros are dropped, but the
                // final digit always goes out so that zero prints as one '0'.
                if (r_seen || w_digit != 4'd0 || r_cnt == CNT_W'(1)) begin
                    n_strobe        = 1'b1;
                    n_seen          = 1'b1;
                    n_res.char_out  = digit_char(w_digit, r_op == OP_HEXU);
                    n_res.last_char = (r_cnt == CNT_W'(1));
                end
                if (w_is_dec) begin
                    n_bcd = r_bcd << 4;
                end else begin
                    case (r_op)
                        OP_BIN:  n_sh = r_sh << 1;
                        OP_OCT:  n_sh = r_sh << 3;
                        default: n_sh = r_sh << 4;
                    endcase
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_seen   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_seen   <= n_seen;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_sh  <= n_sh;
        r_bcd <= n_bcd;
        r_res <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire

// ===== bench/integer_to_radix_ascii_tb.sv =====
import ira_pkg::*;

// Keeps the characters that the block still owes, in the order it must send
// them, and compares every strobed character with the oldest one.
class digit_stream_checker;
    t_res pending_chars[$];
    int   mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Converts one accepted request into its character sequence.
    function void note_request(t_req r);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic               upper;
        logic               neg;
        logic [3:0]         d;
        logic [CHAR_W-1:0]  digits[$];
        mag   = r.value;
        upper = 1'b0;
        neg   = 1'b0;
        case (r.opcode)
            OP_SDEC: begin
                radix = 10;
                // Two's complement negate; the most negative word stays 2^31.
                if (mag[VALUE_W-1]) begin
                    neg = 1'b1;
                    mag = ~mag + 1'b1;
                end
            end
            OP_UDEC: radix = 10;
            OP_BIN:  radix = 2;
            OP_OCT:  radix = 8;
            OP_HEXL: radix = 16;
            OP_HEXU: begin
                radix = 16;
                upper = 1'b1;
            end
            default: return;
        endcase
        // The do-while leaves a single '0' for a zero word.
        do begin
            d = 4'(mag % radix);
            digits.push_front(d < 4'd10 ? ASC_ZERO + CHAR_W'(d)
                              : (upper ? ASC_UPA : ASC_LOWA) + CHAR_W'(d) - CHAR_W'(10));
            mag = mag / radix;
        end while (mag != 0);
        if (neg) begin
            pending_chars.push_back('{char_out: ASC_MINUS, last_char: 1'b0});
        end
        foreach (digits[i]) begin
            pending_chars.push_back('{char_out: digits[i],
                                      last_char: (i == digits.size() - 1)});
        end
    endfunction

    function void check_char(t_res got);
        t_res want;
        if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected character %h last %b", got.char_out, got.last_char);
            end
            return;
        end
        want = pending_chars.pop_front();
        if (got.char_out !== want.char_out || got.last_char !== want.last_char) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("character error: expected char %h last %b, got char %h last %b",
                         want.char_out, want.last_char, got.char_out, got.last_char);
            end
        end
    endfunction
endclass

module integer_to_radix_ascii_tb;

    // The two format codes that the block must ignore.
    localparam logic [OPCODE_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNDEF_HI = 3'd7;

    // A decimal request keeps the block busy through its double-dabble pass
    // before its first character, so a long stretch with no request taken and
    // no character strobed means the block has hung.
    localparam int QUIET_LIMIT = 2000;

    // Cycles to wait after the last expected character, to catch extras.
    localparam int DRAIN_CYCLES = 64;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req   = '0;
    logic o_busy;
    logic o_strobe;
    t_res o_res;

    // Percentage of cycles in which the request side holds back.
    int sender_idle_pct = 0;

    // Cycles since the last accepted request or strobed character.
    int quiet_cycles = 0;

    digit_stream_checker board = new();

    integer_to_radix_ascii DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor. Right after the edge the block's outputs and our own drives
    // still hold the values that the edge saw, so a request counts as taken
    // exactly when the block took it. Characters are checked before the new
    // request is noted; a request never produces a character on its own edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                board.check_char(o_res);
            end
            if (i_start && !o_busy) begin
                board.note_request(i_req);
            end
            if (o_strobe || (i_start && !o_busy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // Watchdog: a hung block ends the run as a failure.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("integer_to_radix_ascii: mismatch");
        $finish;
    end

    // Offers one request, after a random number of idle cycles, and returns
    // at the edge where the block takes it. Start stays high while busy, so
    // back-to-back requests never drop start within one time step.
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy !== 1'b0);
    endtask

    // Random requests. The values are shaped so that digit counts of every
    // length turn up: full words, words cut short by a shift, values around
    // powers of two, and small numbers. Ignored codes do not count.
    task automatic run_phase(input int idle_pct, input int n_items);
        t_req r;
        int   made;
        int   k;
        sender_idle_pct = idle_pct;
        made = 0;
        while (made < n_items) begin
            case ($urandom_range(3))
                0: r.value = $urandom;
                1: r.value = $urandom >> $urandom_range(31);
                2: begin
                    k = $urandom_range(31);
                    case ($urandom_range(2))
                        0:       r.value = 32'd1 << k;
                        1:       r.value = (32'd1 << k) - 32'd1;
                        default: r.value = -(32'd1 << k);
                    endcase
                end
                default: r.value = $urandom_range(20);
            endcase
            if ($urandom_range(19) == 0) begin
                r.opcode = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
            end else begin
                r.opcode = OPCODE_W'($urandom_range(int'(OP_HEXU), int'(OP_SDEC)));
                made++;
            end
            send_request(r);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: zero and the all-ones word in every format, the
        // most negative and most positive signed words, minus one, both hex
        // letter cases, the ignored codes and the decimal digit-count step.
        sender_idle_pct = 17;
        for (int op = OP_SDEC; op <= OP_HEXU; op++) begin
            send_request('{value: 32'h0000_0000, opcode: OPCODE_W'(op)});
            send_request('{value: 32'hFFFF_FFFF, opcode: OPCODE_W'(op)});
        end
        send_request('{value: 32'h8000_0000, opcode: OP_SDEC});
        send_request('{value: 32'h7FFF_FFFF, opcode: OP_SDEC});
        send_request('{value: 32'h8000_0000, opcode: OP_UDEC});
        send_request('{value: 32'hABCD_EF09, opcode: OP_HEXL});
        send_request('{value: 32'hABCD_EF09, opcode: OP_HEXU});
        send_request('{value: 32'h1234_5678, opcode: OP_OCT});
        send_request('{value: 32'h0000_0001, opcode: OP_BIN});
        send_request('{value: 32'h1234_5678, opcode: OP_UNDEF_LO});
        send_request('{value: 32'hFFFF_FFFF, opcode: OP_UNDEF_HI});
        send_request('{value: 32'd9, opcode: OP_UDEC});
        send_request('{value: 32'd10, opcode: OP_UDEC});

        // The sender's idle rate changes between phases; the receiver side
        // has no way to stall, so only the request side idles.
        run_phase(17, 84);
        run_phase(66, 84);
        run_phase(0, 84);
        i_start <= 1'b0;

        // Wait for every owed character, then a little longer for strays.
        while (board.pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("integer_to_radix_ascii: match");
        end else begin
            $display("integer_to_radix_ascii: mismatch");
        end
        $finish;
    end

endmodule
